/* design/scrp_pkg.sv */
package scrp_pkg;

  // Byte position counter width (longest request is 7 + 255 bytes).
  localparam int COUNT_W = 9;

  // Default depth of the request queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Output bus width.
  localparam int OUT_DATA_W = 216;

  // Request field values.
  localparam logic [7:0] SOCKS_VERSION = 8'd5;
  localparam logic [7:0] CMD_CONNECT   = 8'd1;
  localparam logic [7:0] ATYP_IPV4     = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
  localparam logic [7:0] ATYP_IPV6     = 8'd4;

  // Byte positions within a request.
  localparam logic [COUNT_W-1:0] POS_VERSION   = 9'd0;
  localparam logic [COUNT_W-1:0] POS_COMMAND   = 9'd1;
  localparam logic [COUNT_W-1:0] POS_RESERVED  = 9'd2;
  localparam logic [COUNT_W-1:0] POS_ATYP      = 9'd3;
  localparam logic [COUNT_W-1:0] POS_NAME_LEN  = 9'd4;
  localparam logic [COUNT_W-1:0] POS_V4_LAST   = 9'd7;
  localparam logic [COUNT_W-1:0] POS_V4_PORT_H = 9'd8;
  localparam logic [COUNT_W-1:0] POS_V4_PORT_L = 9'd9;
  localparam logic [COUNT_W-1:0] POS_V6_LAST   = 9'd19;
  localparam logic [COUNT_W-1:0] POS_V6_PORT_H = 9'd20;
  localparam logic [COUNT_W-1:0] POS_V6_PORT_L = 9'd21;
  localparam logic [COUNT_W-1:0] NAME_PORT_H_OFS = 9'd5;
  localparam logic [COUNT_W-1:0] NAME_PORT_L_OFS = 9'd6;

  // Verdict status codes.
  localparam logic [1:0] STATUS_PARSED      = 2'd0;
  localparam logic [1:0] STATUS_REPLY_ERROR = 2'd1;
  localparam logic [1:0] STATUS_BAD_VERSION = 2'd2;

  // Reply codes.
  localparam logic [3:0] REPLY_SUCCESS      = 4'd0;
  localparam logic [3:0] REPLY_CMD_UNSUPP   = 4'd7;
  localparam logic [3:0] REPLY_ATYP_UNSUPP  = 4'd8;

  // Address family codes.
  localparam logic [2:0] FAMILY_NONE = 3'd0;
  localparam logic [2:0] FAMILY_IPV4 = 3'd4;
  localparam logic [2:0] FAMILY_IPV6 = 3'd6;

  // Result kind codes.
  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_COMMAND,
    OP_ADDR,
    OP_PORT_HIGH,
    OP_NAME_LENGTH,
    OP_NAME,
    OP_VERDICT
  } op_t;

  // One queued operation.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [1:0] status;
    logic [3:0] reply;
    logic [2:0] family;
  } q_item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* design/socks_connect_request_parser_core.sv */
// SOCKS5 connect request parser. Request bytes enter on the slave stream one per
// cycle while the request queue is not full, tuser marking the first byte of a
// new request; then every byte can be taken in the cycle after the previous one,
// so the sustained rate is one byte per clock. The front stage tracks the byte
// position and checks version, command, reserved byte and address type, then
// queues an operation for the back stage, which gathers address and port and
// drives the registered master stream. A result is registered in a queue slot
// and then in the output register. Input stalls only when the request queue
// (QUEUE_DEPTH entries) is full, as when the master side holds tready low.
// Domain name bytes come out as name results (tuser 0); each request ends with one
// verdict (tuser 1), and bytes after it are dropped until the next start byte.
module socks_connect_request_parser_core #(
  parameter int QUEUE_DEPTH = scrp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] data_byte
  input  logic                            s_tuser,  // [0] frame_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] name_byte, [9:8] status, [13:10] reply_code, [21:14] command,
  // [24:22] address_family, [40:25] dest_port, [72:41] ipv4_address,
  // [136:73] ipv6_high, [200:137] ipv6_low, [208:201] name_length, rest zero
  output logic [scrp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser   // [0] out_kind
);
  import scrp_pkg::*;

  logic      accept;
  logic      q_push;
  logic      q_pop;
  q_item_t   q_in;
  q_item_t   q_out;
  q_status_t q_stat;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // Front: byte classification and request checks.
  scrp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (s_tdata),
    .in_start (s_tuser),
    .push     (q_push),
    .item     (q_in)
  );

  // Operation queue between the two stages.
  scrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .stat      (q_stat)
  );

  // Back: field capture and result register.
  scrp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (q_out),
    .empty     (q_stat.empty),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_data  (m_tdata)
  );

`ifndef ASSERT_OFF
  // The front only queues an operation for a byte that was taken.
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> accept)
    else $error("queue push without an accepted byte");

  // The back never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  // A name result carries nothing above the name byte.
  a_name_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_NAME) |-> (m_tdata[OUT_DATA_W-1:8] == '0))
    else $error("name result with nonzero verdict fields");

  // No result is presented in the first cycle after reset is released.
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

/* design/scrp_front.sv */
module scrp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  input  logic             in_start,
  output logic             push,
  output scrp_pkg::q_item_t item
);
  import scrp_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               finished, finished_next;
  logic [7:0]         version_value, version_value_next;
  logic [7:0]         command_value, command_value_next;
  logic [7:0]         reserved_value, reserved_value_next;
  logic [7:0]         address_type, address_type_next;
  logic [7:0]         domain_length, domain_length_next;

  logic [COUNT_W-1:0] k;
  logic [COUNT_W-1:0] name_last;
  logic [7:0]         atyp_cur;

  // Position of this byte; a start byte is always position zero.
  assign k         = in_start ? '0 : byte_count;
  assign atyp_cur  = in_start ? '0 : address_type;
  assign name_last = POS_NAME_LEN + {1'b0, domain_length};

  // Classify the byte and decide which operation goes to the back.
  always_comb begin
    byte_count_next     = byte_count;
    finished_next       = finished;
    version_value_next  = version_value;
    command_value_next  = command_value;
    reserved_value_next = reserved_value;
    address_type_next   = address_type;
    domain_length_next  = domain_length;
    push                = 1'b0;
    item = '{op: OP_NAME, data: in_byte, status: STATUS_PARSED,
             reply: REPLY_SUCCESS, family: FAMILY_NONE};

    if (accept && (in_start || !finished)) begin
      finished_next   = 1'b0;
      byte_count_next = k + 1'b1;
      if (in_start) begin
        command_value_next  = '0;
        reserved_value_next = '0;
        address_type_next   = '0;
        domain_length_next  = '0;
      end
      case (k)
        POS_VERSION: begin
          version_value_next = in_byte;
        end
        POS_COMMAND: begin
          command_value_next = in_byte;
          item.op = OP_COMMAND;
          push    = 1'b1;
        end
        POS_RESERVED: begin
          reserved_value_next = in_byte;
        end
        POS_ATYP: begin
          address_type_next = in_byte;
          if (version_value != SOCKS_VERSION) begin
            item.op = OP_VERDICT;
            item.status = STATUS_BAD_VERSION;
            push = 1'b1;
            finished_next = 1'b1;
          end else if (command_value != CMD_CONNECT || reserved_value != 8'd0) begin
            item.op = OP_VERDICT;
            item.status = STATUS_REPLY_ERROR;
            item.reply = REPLY_CMD_UNSUPP;
            push = 1'b1;
            finished_next = 1'b1;
          end else if (in_byte != ATYP_IPV4 && in_byte != ATYP_DOMAIN &&
                       in_byte != ATYP_IPV6) begin
            item.op = OP_VERDICT;
            item.status = STATUS_REPLY_ERROR;
            item.reply = REPLY_ATYP_UNSUPP;
            push = 1'b1;
            finished_next = 1'b1;
          end
        end
        default: begin
          finished_next = 1'b1;
          if (atyp_cur == ATYP_IPV4) begin
            if (k <= POS_V4_LAST) begin
              item.op = OP_ADDR;
              push = 1'b1;
              finished_next = 1'b0;
            end else if (k == POS_V4_PORT_H) begin
              item.op = OP_PORT_HIGH;
              push = 1'b1;
              finished_next = 1'b0;
            end else if (k == POS_V4_PORT_L) begin
              item.op = OP_VERDICT;
              item.family = FAMILY_IPV4;
              push = 1'b1;
            end
          end else if (atyp_cur == ATYP_IPV6) begin
            if (k <= POS_V6_LAST) begin
              item.op = OP_ADDR;
              push = 1'b1;
              finished_next = 1'b0;
            end else if (k == POS_V6_PORT_H) begin
              item.op = OP_PORT_HIGH;
              push = 1'b1;
              finished_next = 1'b0;
            end else if (k == POS_V6_PORT_L) begin
              item.op = OP_VERDICT;
              item.family = FAMILY_IPV6;
              push = 1'b1;
            end
          end else if (atyp_cur == ATYP_DOMAIN) begin
            if (k == POS_NAME_LEN) begin
              domain_length_next = in_byte;
              push = 1'b1;
              if (in_byte == 8'd0) begin
                item.op = OP_VERDICT;
                item.status = STATUS_REPLY_ERROR;
                item.reply = REPLY_ATYP_UNSUPP;
              end else begin
                item.op = OP_NAME_LENGTH;
                finished_next = 1'b0;
              end
            end else if (k <= name_last) begin
              item.op = OP_NAME;
              push = 1'b1;
              finished_next = 1'b0;
            end else if (k == name_last + 1'b1) begin
              item.op = OP_PORT_HIGH;
              push = 1'b1;
              finished_next = 1'b0;
            end else if (k == name_last + 2'd2) begin
              item.op = OP_VERDICT;
              push = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      finished       <= 1'b1;
      version_value  <= '0;
      command_value  <= '0;
      reserved_value <= '0;
      address_type   <= '0;
      domain_length  <= '0;
    end else begin
      byte_count     <= byte_count_next;
      finished       <= finished_next;
      version_value  <= version_value_next;
      command_value  <= command_value_next;
      reserved_value <= reserved_value_next;
      address_type   <= address_type_next;
      domain_length  <= domain_length_next;
    end
  end

endmodule

/* design/scrp_queue.sv */
module scrp_queue #(
  parameter int DEPTH = scrp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scrp_pkg::q_item_t   push_item,
  input  logic                pop,
  output scrp_pkg::q_item_t   pop_item,
  output scrp_pkg::q_status_t stat
);
  import scrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_item_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign pop_item   = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/scrp_back.sv */
module scrp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  scrp_pkg::q_item_t             item,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [scrp_pkg::OUT_DATA_W-1:0] out_data
);
  import scrp_pkg::*;

  logic [7:0]  command_value;
  logic [63:0] address_upper;
  logic [63:0] address_lower;
  logic [7:0]  port_high_byte;
  logic [7:0]  domain_length;

  logic        emits;
  logic        parsed;
  logic [7:0]  name_byte;
  logic [15:0] dest_port;
  logic [31:0] ipv4_address;
  logic [63:0] ipv6_high;
  logic [63:0] ipv6_low;
  logic [7:0]  name_length;
  logic [2:0]  family;

  // A result-producing operation waits for room in the output register.
  assign emits = (item.op == OP_NAME) || (item.op == OP_VERDICT);
  assign pop   = !empty && (!emits || !out_valid || out_ready);

  // Result fields for the operation at the head of the queue.
  always_comb begin
    parsed       = (item.op == OP_VERDICT) && (item.status == STATUS_PARSED);
    name_byte    = (item.op == OP_NAME) ? item.data : 8'd0;
    family       = parsed ? item.family : FAMILY_NONE;
    dest_port    = parsed ? {port_high_byte, item.data} : 16'd0;
    ipv4_address = (parsed && item.family == FAMILY_IPV4) ? address_lower[31:0] : 32'd0;
    ipv6_high    = (parsed && item.family == FAMILY_IPV6) ? address_upper : 64'd0;
    ipv6_low     = (parsed && item.family == FAMILY_IPV6) ? address_lower : 64'd0;
    name_length  = (parsed && item.family == FAMILY_NONE) ? domain_length : 8'd0;
  end

  // Captured request fields.
  always_ff @(posedge clk) begin
    if (pop) begin
      case (item.op)
        OP_COMMAND:     command_value <= item.data;
        OP_ADDR: begin
          address_upper <= {address_upper[55:0], address_lower[63:56]};
          address_lower <= {address_lower[55:0], item.data};
        end
        OP_PORT_HIGH:   port_high_byte <= item.data;
        OP_NAME_LENGTH: domain_length  <= item.data;
        default: begin
        end
      endcase
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop && emits) begin
      if (item.op == OP_NAME) begin
        out_kind <= KIND_NAME;
        out_data <= {{(OUT_DATA_W - 8){1'b0}}, name_byte};
      end else begin
        out_kind <= KIND_VERDICT;
        out_data <= {7'd0, name_length, ipv6_low, ipv6_high, ipv4_address, dest_port,
                     family, command_value, item.reply, item.status, 8'd0};
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
